// File: hdl/bpfa_pkg.sv
// Shared types, codes and constants of the bitmap page frame allocator.
// No dependencies; imported by the allocator top level and its checker.
`default_nettype none

package bpfa_pkg;

    // Default number of frames managed by the bitmap
    localparam int MAX_FRAMES_DEF = 8192;

    // Bitmap row: one memory word covers this many frames
    localparam int WORD_BITS  = 64;
    localparam int WORD_IDX_W = $clog2(WORD_BITS);

    // Field widths of the ports
    localparam int KIND_W    = 2;
    localparam int FRAME_W   = 13;
    localparam int COUNT_W   = 14;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Row counter for a scan: holds the row count of a 14-bit limit
    localparam int ROW_CNT_W = COUNT_W - WORD_IDX_W + 1;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd2;

    // Register reset values
    localparam logic [COUNT_W-1:0] TOTAL_RST    = 14'd8192;
    localparam logic [COUNT_W-1:0] LOW_RST      = 14'd256;
    localparam logic [COUNT_W-1:0] RESERVED_RST = 14'd1024;

    // Lowest set bit of a bitmap row
    typedef struct packed {
        logic                  found;
        logic [WORD_IDX_W-1:0] idx;
    } t_first;

    function automatic t_first first_set(input logic [WORD_BITS-1:0] v);
        t_first r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.idx   = WORD_IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/bpfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/bitmap_page_frame_allocator.sv
// First-fit bitmap page frame allocator, top level.
// Depends on bpfa_pkg and bpfa_ram.
//
// Usage:
//   Requests enter on start/i_kind/i_frame and are taken at a clock edge with
//   start high and busy low. One request is worked at a time. Each request
//   gives one result on o_status/o_granted_frame/o_used_count, shown for one
//   cycle with o_strobe; the receiver cannot stall it. A new request may be
//   taken at the edge that ends the cycle showing the previous result.
//   Work per request:
//     free, mark available, reserve: one bitmap row read, modify and, if the
//       frame changes, write back.
//     allocate: the scan stops at the row that holds the first free frame, or
//       after the last row below the limit when no frame is free; the scan
//       reads one 64-frame row of the bitmap memory per cycle.
//   Registers are written on i_cfg_we at any time; they are meant to change
//   only while the block is idle.
//   Reset: a clearing pass writes every bitmap row to all ones (all frames
//   used), one row a cycle; busy stays high until it ends.
`default_nettype none

module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [COUNT_W-1:0]   i_cfg_data,
    // request channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [KIND_W-1:0]    i_kind,
    input  wire logic [FRAME_W-1:0]   i_frame,
    // result channel
    output logic                      o_strobe,
    output logic [STATUS_W-1:0]       o_status,
    output logic [FRAME_W-1:0]        o_granted_frame,
    output logic [COUNT_W-1:0]        o_used_count
);

    localparam int ROWS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int UW   = $clog2(MAX_FRAMES + 1);
    localparam logic [31:0] MAXF = 32'(MAX_FRAMES);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SCAN
    } t_state;

    // Registers
    t_state                 r_state, n_state;
    logic [AW-1:0]          r_clr, n_clr;
    logic [ROW_CNT_W-1:0]   r_row, n_row;
    logic [UW-1:0]          r_used, n_used;
    logic [KIND_W-1:0]      r_kind, n_kind;
    logic [FRAME_W-1:0]     r_frame, n_frame;
    logic                   r_strobe, n_strobe;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [FRAME_W-1:0]     r_granted, n_granted;
    logic [COUNT_W-1:0]     r_total, r_low, r_resv;

    // Bitmap memory ports
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0]   ram_wdata, ram_rdata;

    // Derived limit and scan terms
    logic [COUNT_W-1:0]          lim;
    logic [ROW_CNT_W-1:0]        n_rows;
    logic [ROW_CNT_W-1:0]        lim_row;
    logic [WORD_BITS-1:0]        row_mask;
    t_first                      first;
    logic                        in_range;
    logic                        bit_used;
    logic [WORD_BITS-1:0]        bit_sel;

    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROWS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RST;
            r_low   <= LOW_RST;
            r_resv  <= RESERVED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOTAL:    r_total <= i_cfg_data;
                CFG_LOW:      r_low   <= i_cfg_data;
                CFG_RESERVED: r_resv  <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Effective limit, clamped to the bitmap size
    assign lim     = (32'(r_total) < MAXF) ? r_total : MAXF[COUNT_W-1:0];
    assign n_rows  = ROW_CNT_W'((32'(lim) + 32'(WORD_BITS - 1)) >> WORD_IDX_W);
    assign lim_row = ROW_CNT_W'(lim >> WORD_IDX_W);

    // Free frames of the row under scan that lie below the limit
    assign row_mask = (r_row < lim_row) ? '1
                    : ((WORD_BITS'(1) << lim[WORD_IDX_W-1:0]) - WORD_BITS'(1));
    assign first    = first_set(~ram_rdata & row_mask);

    // Single-frame terms
    assign in_range = {1'b0, r_frame} < lim;
    assign bit_sel  = WORD_BITS'(1) << r_frame[WORD_IDX_W-1:0];
    assign bit_used = |(ram_rdata & bit_sel);

    // Next state, memory access and result
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_row     = r_row;
        n_used    = r_used;
        n_kind    = r_kind;
        n_frame   = r_frame;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_granted = r_granted;
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '1;
        ram_raddr = AW'(r_row + ROW_CNT_W'(1));

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + AW'(1);
                if (r_clr == AW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_kind == KIND_ALLOC) begin
                    ram_raddr = '0;
                end else begin
                    ram_raddr = AW'(i_frame >> WORD_IDX_W);
                end
                if (start) begin
                    n_kind  = i_kind;
                    n_frame = i_frame;
                    n_row   = '0;
                    n_state = (i_kind == KIND_ALLOC) ? S_SCAN : S_MOD;
                end
            end

            // Row of the addressed frame is on the read port
            S_MOD: begin
                ram_waddr = AW'(r_frame >> WORD_IDX_W);
                ram_wdata = ram_rdata & ~bit_sel;
                n_status  = ST_OK;
                n_granted = '0;
                n_strobe  = 1'b1;
                n_state   = S_IDLE;
                case (r_kind)
                    KIND_FREE: begin
                        if (({1'b0, r_frame} < r_resv) || !in_range) begin
                            n_status = ST_BLOCKED;
                        end else if (!bit_used) begin
                            n_status = ST_DOUBLE;
                        end else begin
                            ram_we = 1'b1;
                            n_used = r_used - UW'(1);
                        end
                    end
                    KIND_MARK: begin
                        if (({1'b0, r_frame} >= r_low) && in_range && bit_used) begin
                            ram_we = 1'b1;
                            n_used = r_used - UW'(1);
                        end
                    end
                    default: begin
                        ram_wdata = ram_rdata | bit_sel;
                        if (in_range && !bit_used) begin
                            ram_we = 1'b1;
                            n_used = r_used + UW'(1);
                        end
                    end
                endcase
            end

            // Row r_row is on the read port, next row is being read
            S_SCAN: begin
                ram_waddr = AW'(r_row);
                ram_wdata = ram_rdata | (WORD_BITS'(1) << first.idx);
                if (first.found) begin
                    ram_we    = 1'b1;
                    n_used    = r_used + UW'(1);
                    n_status  = ST_OK;
                    n_granted = FRAME_W'({r_row, first.idx});
                    n_strobe  = 1'b1;
                    n_state   = S_IDLE;
                end else if ((r_row + ROW_CNT_W'(1)) >= n_rows) begin
                    n_status  = ST_OOM;
                    n_granted = '0;
                    n_strobe  = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_row = r_row + ROW_CNT_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_row    <= '0;
            r_used   <= UW'(MAX_FRAMES);
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_row    <= n_row;
            r_used   <= n_used;
            r_strobe <= n_strobe;
        end
        r_kind    <= n_kind;
        r_frame   <= n_frame;
        r_status  <= n_status;
        r_granted <= n_granted;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_granted_frame = r_granted;
    assign o_used_count    = COUNT_W'(r_used);

endmodule

`default_nettype wire

// File: hdl/bpfa_checker.sv
// Port-level checks of the bitmap page frame allocator, bound to its top level.
// Depends on bpfa_pkg and bitmap_page_frame_allocator.
`default_nettype none

module bpfa_checker
    import bpfa_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                o_strobe,
    input wire logic [STATUS_W-1:0] o_status,
    input wire logic [FRAME_W-1:0]  o_granted_frame
);

    // A taken request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy next cycle");

    // Results cannot come in two consecutive cycles
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

    // A result always ends a busy period
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without preceding work");

    // Only a successful request may carry a granted frame
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ST_OK)) |-> (o_granted_frame == '0))
        else $error("failed request reports a granted frame");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_status        (o_status),
    .o_granted_frame (o_granted_frame)
);

`default_nettype wire
